>>> hw/rtl/kmc_pkg.sv
package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int COORD_W      = 16;
  localparam int PT_AW        = 10;
  localparam int CL_AW        = 4;
  localparam int CNT_W        = 11;
  localparam int SUM_W        = 26;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int DIST_W       = SQ_W + 1;
  localparam int CFG_AW       = 4;

  typedef enum logic [2:0] {
    CMD_LDC = 3'd0,
    CMD_LDP = 3'd1,
    CMD_RUN = 3'd2,
    CMD_RDL = 3'd3,
    CMD_RDC = 3'd4
  } kmc_cmd_t;

  typedef enum logic [1:0] {
    REG_NCL = 2'd0,
    REG_MAXIT = 2'd1,
    REG_THR = 2'd2
  } kmc_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LBL,
    ST_ITER,
    ST_PRD,
    ST_ISSUE,
    ST_DRAIN,
    ST_UPD,
    ST_DIVX,
    ST_DIVY,
    ST_FIN
  } kmc_state_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [CL_AW-1:0]  cid;
    logic [SQ_W-1:0]   sqx;
    logic [SQ_W-1:0]   sqy;
  } kmc_dres_t;

endpackage

>>> hw/rtl/kmc_in_if.sv
interface kmc_in_if import kmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                command;
  logic [PT_AW-1:0]          index;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      last;

  modport source(output valid, command, index, x_coord, y_coord, last, input ready);
  modport sink(input valid, command, index, x_coord, y_coord, last, output ready);
endinterface

>>> hw/rtl/kmc_out_if.sv
interface kmc_out_if import kmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CL_AW-1:0]          cluster_id;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      converged;
  logic [7:0]                iterations_used;

  modport source(output valid, cluster_id, out_x, out_y, converged, iterations_used,
                 input ready);
  modport sink(input valid, cluster_id, out_x, out_y, converged, iterations_used,
               output ready);
endinterface

>>> hw/rtl/kmc_div.sv
module kmc_div import kmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/kmc_dist.sv
module kmc_dist import kmc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      issue_vld,
  input  logic                      issue_last,
  input  logic [CL_AW-1:0]          issue_cid,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  output kmc_dres_t                 res
);

  logic                 s1_vld_r, s1_last_r;
  logic [CL_AW-1:0]     s1_cid_r;
  logic [COORD_W-1:0]   adx_r, ady_r;
  logic                 s2_vld_r, s2_last_r;
  logic [CL_AW-1:0]     s2_cid_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r;
  logic signed [COORD_W:0] difx, dify;
  logic [COORD_W:0]     absx, absy;

  assign difx = {px[COORD_W-1], px} - {cx[COORD_W-1], cx};
  assign dify = {py[COORD_W-1], py} - {cy[COORD_W-1], cy};
  assign absx = difx[COORD_W] ? -difx : difx;
  assign absy = dify[COORD_W] ? -dify : dify;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= issue_last;
    s1_cid_r  <= issue_cid;
    adx_r     <= absx[COORD_W-1:0];
    ady_r     <= absy[COORD_W-1:0];
    s2_last_r <= s1_last_r;
    s2_cid_r  <= s1_cid_r;
    sqx_r     <= adx_r * adx_r;
    sqy_r     <= ady_r * ady_r;
  end

  assign res.vld  = s2_vld_r;
  assign res.last = s2_last_r;
  assign res.cid  = s2_cid_r;
  assign res.sqx  = sqx_r;
  assign res.sqy  = sqy_r;

endmodule

>>> hw/rtl/kmeans_cluster_engine.sv
// Lloyd k-means engine for 2-D signed Q8.8 points. Every command waits for a free output
// register; a label read also passes through a separate state for the registered label read.
// After reset the block sweeps the whole label memory to zero and accepts no item meanwhile.
// Each iteration assigns every point: a point read, then the distance pipeline fed one
// centroid a cycle, then a drain of that pipeline. The bit-serial mean divider then does x
// and y one after the other for every non-empty cluster; empty clusters are skipped.
// Configuration goes over the APB port at 0x0, 0x4 and 0x8.
module kmeans_cluster_engine import kmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  kmc_in_if.sink            in_ch,
  kmc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  kmc_state_t state_r, state_nxt;

  logic [4:0]            ncl_r;
  logic [7:0]            maxit_r;
  logic [COORD_W-1:0]    thr_r;
  logic [4:0]            k_eff;
  logic [PT_AW-1:0]      clr_r;
  logic [CNT_W-1:0]      npt_r;
  logic [PT_AW-1:0]      p_r;
  logic [4:0]            c_r;
  logic [CL_AW-1:0]      cu;
  logic [7:0]            iters_r;
  logic                  moved_r;
  logic                  conv_r;
  logic [7:0]            used_r;

  logic [2*COORD_W-1:0]  pt_mem [MAX_POINTS];
  logic [2*COORD_W-1:0]  pt_q_r;
  logic [CL_AW-1:0]      lbl_mem [MAX_POINTS];
  logic [CL_AW-1:0]      lbl_q_r;

  logic signed [COORD_W-1:0] cen_x_r [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] cen_y_r [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sx_r [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sy_r [MAX_CLUSTERS];
  logic [CNT_W-1:0]          cnt_r [MAX_CLUSTERS];

  logic [DIST_W-1:0]     best_r;
  logic [CL_AW-1:0]      blab_r;
  logic signed [COORD_W:0] qx_r;
  logic                  sgn_r;

  logic                  in_acc, cfg_we;
  logic                  in_ready, pt_rd_en, issue_vld, issue_last, div_start, load_out;
  logic                  lbl_we;
  logic [PT_AW-1:0]      lbl_wa;
  logic [CL_AW-1:0]      lbl_wd;
  logic [CL_AW-1:0]      cen_a;
  kmc_dres_t             dres;
  logic [DIST_W-1:0]     dsum;
  logic                  better, acc_pt;
  logic [CL_AW-1:0]      fin;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]      mag, dvd, quo;
  logic                  div_done;
  logic signed [COORD_W:0] mean;
  logic signed [COORD_W+1:0] dmx, dmy;
  logic [COORD_W+1:0]    amx, amy;
  logic                  cl_moved;
  logic                  out_valid_r;
  logic [CL_AW-1:0]      o_cid_r;
  logic signed [COORD_W-1:0] o_x_r, o_y_r;
  logic                  o_conv_r;
  logic [7:0]            o_iters_r;

  assign in_acc = in_ch.valid && in_ready;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cu     = c_r[CL_AW-1:0];
  assign k_eff  = (ncl_r == 5'd0) ? 5'd1 :
                  (ncl_r > 5'(MAX_CLUSTERS)) ? 5'(MAX_CLUSTERS) : ncl_r;

  always_comb begin
    unique case (kmc_reg_t'(paddr[3:2]))
      REG_NCL:   prdata = {27'd0, ncl_r};
      REG_MAXIT: prdata = {24'd0, maxit_r};
      REG_THR:   prdata = {16'd0, thr_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r   <= 5'd4;
      maxit_r <= 8'd100;
      thr_r   <= 16'd1;
    end else if (cfg_we) begin
      unique case (kmc_reg_t'(paddr[3:2]))
        REG_NCL:   ncl_r   <= pwdata[4:0];
        REG_MAXIT: maxit_r <= pwdata[7:0];
        REG_THR:   thr_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  kmc_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_vld  (issue_vld),
    .issue_last (issue_last),
    .issue_cid  (cu),
    .px         (pt_q_r[2*COORD_W-1:COORD_W]),
    .py         (pt_q_r[COORD_W-1:0]),
    .cx         (cen_x_r[cen_a]),
    .cy         (cen_y_r[cen_a]),
    .res        (dres)
  );

  assign dsum   = {1'b0, dres.sqx} + {1'b0, dres.sqy};
  assign better = (dres.cid == '0) || (dsum < best_r);
  assign fin    = better ? dres.cid : blab_r;
  assign acc_pt = dres.vld && dres.last;

  assign sel_sum = (state_r == ST_UPD) ? sx_r[cu] : sy_r[cu];
  assign mag     = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign dvd     = mag + SUM_W'(cnt_r[cu] >> 1);

  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (cnt_r[cu]),
    .done     (div_done),
    .quotient (quo)
  );

  assign mean = sgn_r ? -$signed({1'b0, quo[COORD_W-1:0]}) : $signed({1'b0, quo[COORD_W-1:0]});
  assign dmx  = {qx_r[COORD_W], qx_r} - {{2{cen_x_r[cu][COORD_W-1]}}, cen_x_r[cu]};
  assign dmy  = {mean[COORD_W], mean} - {{2{cen_y_r[cu][COORD_W-1]}}, cen_y_r[cu]};
  assign amx  = dmx[COORD_W+1] ? -dmx : dmx;
  assign amy  = dmy[COORD_W+1] ? -dmy : dmy;
  assign cl_moved = (amx > {2'b00, thr_r}) || (amy > {2'b00, thr_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == PT_AW'(MAX_POINTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && in_ch.command == CMD_RUN) state_nxt = ST_ITER;
        else if (in_acc && in_ch.command == CMD_RDL) state_nxt = ST_LBL;
      end
      ST_LBL: state_nxt = ST_IDLE;
      ST_ITER: begin
        if (iters_r == maxit_r || !moved_r) state_nxt = ST_FIN;
        else if (npt_r == '0) state_nxt = ST_UPD;
        else state_nxt = ST_PRD;
      end
      ST_PRD: state_nxt = ST_ISSUE;
      ST_ISSUE: if (issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (acc_pt) state_nxt = ({1'b0, p_r} == npt_r - 1'b1) ? ST_UPD : ST_PRD;
      end
      ST_UPD: begin
        if (c_r == k_eff) state_nxt = ST_ITER;
        else if (cnt_r[cu] != '0) state_nxt = ST_DIVX;
      end
      ST_DIVX: if (div_done) state_nxt = ST_DIVY;
      ST_DIVY: if (div_done) state_nxt = ST_UPD;
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    pt_rd_en   = 1'b0;
    issue_vld  = 1'b0;
    issue_last = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    lbl_we     = 1'b0;
    lbl_wa     = p_r;
    lbl_wd     = fin;
    cen_a      = cu;
    unique case (state_r)
      ST_CLEAR: begin
        lbl_we = 1'b1;
        lbl_wa = clr_r;
        lbl_wd = '0;
      end
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ch.ready;
        cen_a    = in_ch.index[CL_AW-1:0];
        load_out = in_acc && in_ch.command == CMD_RDC;
      end
      ST_LBL:   load_out = 1'b1;
      ST_PRD:   pt_rd_en = 1'b1;
      ST_ISSUE: begin
        issue_vld  = 1'b1;
        issue_last = c_r == k_eff - 1'b1;
      end
      ST_DRAIN: lbl_we = acc_pt;
      ST_UPD:   div_start = c_r != k_eff && cnt_r[cu] != '0;
      ST_DIVX:  div_start = div_done;
      ST_FIN:   load_out = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      npt_r   <= '0;
      iters_r <= '0;
      moved_r <= 1'b0;
      conv_r  <= 1'b0;
      used_r  <= '0;
      p_r     <= '0;
      c_r     <= '0;
    end else begin
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (in_acc && in_ch.command == CMD_LDP && in_ch.last) begin
        npt_r <= {1'b0, in_ch.index} + 1'b1;
      end
      if (in_acc && in_ch.command == CMD_RUN) begin
        iters_r <= '0;
        moved_r <= 1'b1;
      end
      unique case (state_r)
        ST_ITER: begin
          if (state_nxt != ST_FIN) moved_r <= 1'b0;
          p_r <= '0;
          c_r <= '0;
        end
        ST_PRD:   c_r <= '0;
        ST_ISSUE: c_r <= c_r + 1'b1;
        ST_DRAIN: begin
          if (acc_pt) begin
            p_r <= p_r + 1'b1;
            c_r <= '0;
          end
        end
        ST_UPD: begin
          if (c_r == k_eff) iters_r <= iters_r + 1'b1;
          else if (cnt_r[cu] == '0) c_r <= c_r + 1'b1;
        end
        ST_DIVY: begin
          if (div_done) begin
            c_r <= c_r + 1'b1;
            if (cl_moved) moved_r <= 1'b1;
          end
        end
        ST_FIN: begin
          conv_r <= !moved_r;
          used_r <= iters_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.command == CMD_LDP) begin
      pt_mem[in_ch.index] <= {in_ch.x_coord, in_ch.y_coord};
    end
    if (pt_rd_en) pt_q_r <= pt_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    lbl_q_r <= lbl_mem[in_ch.index];
  end

  always_ff @(posedge clk) begin
    if (dres.vld) begin
      if (better) begin
        best_r <= dsum;
        blab_r <= dres.cid;
      end
    end
    if (div_start) sgn_r <= sel_sum[SUM_W-1];
    if (state_r == ST_DIVX && div_done) qx_r <= mean;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.command == CMD_LDC && in_ch.index[PT_AW-1:CL_AW] == '0) begin
      cen_x_r[in_ch.index[CL_AW-1:0]] <= in_ch.x_coord;
      cen_y_r[in_ch.index[CL_AW-1:0]] <= in_ch.y_coord;
    end else if (state_r == ST_DIVY && div_done && cl_moved) begin
      cen_x_r[cu] <= qx_r[COORD_W-1:0];
      cen_y_r[cu] <= mean[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ITER) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else if (state_r == ST_DRAIN && acc_pt) begin
      sx_r[fin]  <= sx_r[fin] + SUM_W'($signed(pt_q_r[2*COORD_W-1:COORD_W]));
      sy_r[fin]  <= sy_r[fin] + SUM_W'($signed(pt_q_r[COORD_W-1:0]));
      cnt_r[fin] <= cnt_r[fin] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_cid_r   <= (state_r == ST_LBL) ? lbl_q_r : '0;
      o_x_r     <= '0;
      o_y_r     <= '0;
      o_conv_r  <= conv_r;
      o_iters_r <= used_r;
      if (state_r == ST_IDLE && in_ch.index[PT_AW-1:CL_AW] == '0) begin
        o_x_r <= cen_x_r[cen_a];
        o_y_r <= cen_y_r[cen_a];
      end
      if (state_r == ST_FIN) begin
        o_conv_r  <= !moved_r;
        o_iters_r <= iters_r;
      end
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.cluster_id      = o_cid_r;
  assign out_ch.out_x           = o_x_r;
  assign out_ch.out_y           = o_y_r;
  assign out_ch.converged       = o_conv_r;
  assign out_ch.iterations_used = o_iters_r;

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.command == CMD_RUN) |=> state_r == ST_ITER)
    else $error("run item did not start an iteration");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVX || state_r == ST_DIVY))
    else $error("divider finished outside the update pass");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> iters_r <= maxit_r)
    else $error("iteration count passed the limit");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN || state_r == ST_LBL) |-> !out_valid_r)
    else $error("result register overwritten");

endmodule
